// ===== rtl/rfcm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the rainbow false color mapper.
// No dependencies; the top level and the testbench refer to its items by scoped names.

package rfcm_pkg;

    // Resolution of the scaled ramp index.
    localparam int INDEX_BITS = 16;

    // Sample and range register width (signed Q16.16).
    localparam int DATA_W = 32;

    // Color channel width and the fixed channel levels.
    localparam int CH_W = 8;
    localparam logic [CH_W-1:0] CH_MAX  = 8'hFF;
    localparam logic [CH_W-1:0] CH_MIN  = 8'h00;
    localparam logic [CH_W-1:0] CH_GRAY = 8'h80;

    // Stream payload widths.
    localparam int S_TDATA_W = DATA_W;
    localparam int M_TDATA_W = 3 * CH_W;

    // Scaled numerator (num * (2^INDEX_BITS - 1)) width.
    localparam int NUM_W = DATA_W + INDEX_BITS;

    // Position bits inside one of the four ramp segments.
    localparam int FRAC_BITS = INDEX_BITS - 2;

    // Pipeline depth: clamp, scale, one stage per quotient bit, color.
    localparam int PIPE_STAGES = INDEX_BITS + 3;

    // Configuration port.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_HIGH = 1'b1;

    localparam logic [DATA_W-1:0] RANGE_LOW_RST  = 32'h0000_0000;
    localparam logic [DATA_W-1:0] RANGE_HIGH_RST = 32'h0001_0000;

    // Ramp segment, selected by the top two index bits.
    typedef enum logic [1:0] {
        SEG_BLUE_CYAN    = 2'd0,
        SEG_CYAN_GREEN   = 2'd1,
        SEG_GREEN_YELLOW = 2'd2,
        SEG_YELLOW_RED   = 2'd3
    } t_seg;

endpackage

// ===== rtl/rainbow_false_color_mapper.sv =====
`timescale 1ns / 1ps
// Rainbow false color mapper: signed Q16.16 sample in, 8-bit RGB out.
// Depends on rfcm_pkg for widths, register indexes and segment codes.

// The block takes one pixel per clock while the output is not stalled, and
// returns one color per pixel, in order. The ramp index comes from a
// restoring divider that resolves one quotient bit per pipeline stage,
// behind one clamp stage and one scaling stage, and ahead of the color
// stage, which is also the output register. A stall on the master side
// freezes the whole pipeline and drops s_axis_tready in the same cycle.
// range_low and range_high must only be written while no pixel is in flight;
// when range_high <= range_low every pixel comes out as mid gray.

module rainbow_false_color_mapper (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    // Configuration write port.
    input  logic                                   i_cfg_we,
    input  logic [rfcm_pkg::CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [rfcm_pkg::DATA_W-1:0]            i_cfg_wdata,

    // Sample stream.
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [rfcm_pkg::S_TDATA_W-1:0]         s_axis_tdata,  // [31:0] sample

    // Color stream.
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [rfcm_pkg::M_TDATA_W-1:0]         m_axis_tdata   // [7:0] red,
                                                                  // [15:8] green,
                                                                  // [23:16] blue
);

    // Configuration registers.
    logic [rfcm_pkg::DATA_W-1:0] r_range_low;
    logic [rfcm_pkg::DATA_W-1:0] r_range_high;

    // Pipeline advance: the whole pipe moves unless the output is held.
    logic w_en;

    // Clamp stage.
    logic                        r_a_vld;
    logic                        r_a_gray;
    logic [rfcm_pkg::DATA_W-1:0] r_a_num;
    logic [rfcm_pkg::DATA_W-1:0] r_a_den;

    // Divider chain; entry 0 is the scaling stage, entry j+1 holds j+1 quotient bits.
    logic                            r_d_vld  [rfcm_pkg::INDEX_BITS+1];
    logic                            r_d_gray [rfcm_pkg::INDEX_BITS+1];
    logic [rfcm_pkg::DATA_W-1:0]     r_d_rem  [rfcm_pkg::INDEX_BITS+1];
    logic [rfcm_pkg::DATA_W-1:0]     r_d_den  [rfcm_pkg::INDEX_BITS+1];
    logic [rfcm_pkg::INDEX_BITS-1:0] r_d_lq   [rfcm_pkg::INDEX_BITS+1];

    // Output register.
    logic                      r_out_vld;
    logic [rfcm_pkg::CH_W-1:0] r_red;
    logic [rfcm_pkg::CH_W-1:0] r_green;
    logic [rfcm_pkg::CH_W-1:0] r_blue;

    // Clamp stage signals.
    logic signed [rfcm_pkg::DATA_W:0] w_v;
    logic signed [rfcm_pkg::DATA_W:0] w_lo;
    logic signed [rfcm_pkg::DATA_W:0] w_hi;
    logic signed [rfcm_pkg::DATA_W:0] w_vc;
    logic                             n_a_gray;
    logic signed [rfcm_pkg::DATA_W:0] n_num_full;
    logic signed [rfcm_pkg::DATA_W:0] n_den_full;

    // Scaling stage signals.
    logic [rfcm_pkg::NUM_W-1:0] n_prod;

    // Divider step signals.
    logic [rfcm_pkg::DATA_W:0]     w_sh   [rfcm_pkg::INDEX_BITS];
    logic [rfcm_pkg::DATA_W:0]     w_diff [rfcm_pkg::INDEX_BITS];
    logic [rfcm_pkg::DATA_W-1:0]   n_rem  [rfcm_pkg::INDEX_BITS];
    logic [rfcm_pkg::INDEX_BITS-1:0] n_lq [rfcm_pkg::INDEX_BITS];

    // Color stage signals.
    logic [rfcm_pkg::INDEX_BITS-1:0]          w_k;
    logic [rfcm_pkg::FRAC_BITS-1:0]           w_f;
    logic [rfcm_pkg::FRAC_BITS:0]             w_sf;
    logic [rfcm_pkg::FRAC_BITS+rfcm_pkg::CH_W-1:0] w_up_full;
    logic [rfcm_pkg::FRAC_BITS+rfcm_pkg::CH_W:0]   w_dn_full;
    logic [rfcm_pkg::CH_W-1:0]                w_up;
    logic [rfcm_pkg::CH_W:0]                  w_dn_wide;
    logic [rfcm_pkg::CH_W-1:0]                w_dn;
    logic [rfcm_pkg::CH_W-1:0]                n_red;
    logic [rfcm_pkg::CH_W-1:0]                n_green;
    logic [rfcm_pkg::CH_W-1:0]                n_blue;

    assign w_en          = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_blue, r_green, r_red};

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_low  <= rfcm_pkg::RANGE_LOW_RST;
            r_range_high <= rfcm_pkg::RANGE_HIGH_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rfcm_pkg::REG_RANGE_LOW:  r_range_low  <= i_cfg_wdata;
                rfcm_pkg::REG_RANGE_HIGH: r_range_high <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the sample to the range and form numerator and denominator.
    always_comb begin
        w_v  = $signed({s_axis_tdata[rfcm_pkg::DATA_W-1], s_axis_tdata});
        w_lo = $signed({r_range_low[rfcm_pkg::DATA_W-1], r_range_low});
        w_hi = $signed({r_range_high[rfcm_pkg::DATA_W-1], r_range_high});
        n_a_gray = (w_hi <= w_lo);
        if (w_v < w_lo) begin
            w_vc = w_lo;
        end else if (w_v > w_hi) begin
            w_vc = w_hi;
        end else begin
            w_vc = w_v;
        end
        n_num_full = w_vc - w_lo;
        n_den_full = w_hi - w_lo;
    end

    // Scale: num * (2^INDEX_BITS - 1) as a shift and a subtract.
    assign n_prod = {r_a_num, {rfcm_pkg::INDEX_BITS{1'b0}}}
                  - {{rfcm_pkg::INDEX_BITS{1'b0}}, r_a_num};

    // Restoring division steps: each brings in one dividend bit and emits one quotient bit.
    always_comb begin
        for (int j = 0; j < rfcm_pkg::INDEX_BITS; j++) begin
            w_sh[j]   = {r_d_rem[j], r_d_lq[j][rfcm_pkg::INDEX_BITS-1]};
            w_diff[j] = w_sh[j] - {1'b0, r_d_den[j]};
            if (!w_diff[j][rfcm_pkg::DATA_W]) begin
                n_rem[j] = w_diff[j][rfcm_pkg::DATA_W-1:0];
                n_lq[j]  = {r_d_lq[j][rfcm_pkg::INDEX_BITS-2:0], 1'b1};
            end else begin
                n_rem[j] = w_sh[j][rfcm_pkg::DATA_W-1:0];
                n_lq[j]  = {r_d_lq[j][rfcm_pkg::INDEX_BITS-2:0], 1'b0};
            end
        end
    end

    // Color ramp from the finished index.
    always_comb begin
        w_k       = r_d_lq[rfcm_pkg::INDEX_BITS];
        w_f       = w_k[rfcm_pkg::FRAC_BITS-1:0];
        w_sf      = {1'b1, {rfcm_pkg::FRAC_BITS{1'b0}}} - {1'b0, w_f};
        w_up_full = {w_f, {rfcm_pkg::CH_W{1'b0}}} - {{rfcm_pkg::CH_W{1'b0}}, w_f};
        w_dn_full = {w_sf, {rfcm_pkg::CH_W{1'b0}}} - {{rfcm_pkg::CH_W{1'b0}}, w_sf};
        w_up      = w_up_full[rfcm_pkg::FRAC_BITS+rfcm_pkg::CH_W-1:rfcm_pkg::FRAC_BITS];
        w_dn_wide = w_dn_full[rfcm_pkg::FRAC_BITS+rfcm_pkg::CH_W:rfcm_pkg::FRAC_BITS];
        w_dn      = w_dn_wide[rfcm_pkg::CH_W] ? rfcm_pkg::CH_MAX
                                              : w_dn_wide[rfcm_pkg::CH_W-1:0];
        if (r_d_gray[rfcm_pkg::INDEX_BITS]) begin
            n_red   = rfcm_pkg::CH_GRAY;
            n_green = rfcm_pkg::CH_GRAY;
            n_blue  = rfcm_pkg::CH_GRAY;
        end else begin
            case (rfcm_pkg::t_seg'(w_k[rfcm_pkg::INDEX_BITS-1 -: 2]))
                rfcm_pkg::SEG_BLUE_CYAN: begin
                    n_red   = rfcm_pkg::CH_MIN;
                    n_green = w_up;
                    n_blue  = rfcm_pkg::CH_MAX;
                end
                rfcm_pkg::SEG_CYAN_GREEN: begin
                    n_red   = rfcm_pkg::CH_MIN;
                    n_green = rfcm_pkg::CH_MAX;
                    n_blue  = w_dn;
                end
                rfcm_pkg::SEG_GREEN_YELLOW: begin
                    n_red   = w_up;
                    n_green = rfcm_pkg::CH_MAX;
                    n_blue  = rfcm_pkg::CH_MIN;
                end
                default: begin
                    n_red   = rfcm_pkg::CH_MAX;
                    n_green = w_dn;
                    n_blue  = rfcm_pkg::CH_MIN;
                end
            endcase
        end
    end

    // Valid bits travel with the data and freeze on a stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld   <= 1'b0;
            r_out_vld <= 1'b0;
            for (int j = 0; j <= rfcm_pkg::INDEX_BITS; j++) begin
                r_d_vld[j] <= 1'b0;
            end
        end else if (w_en) begin
            r_a_vld    <= s_axis_tvalid;
            r_d_vld[0] <= r_a_vld;
            for (int j = 0; j < rfcm_pkg::INDEX_BITS; j++) begin
                r_d_vld[j+1] <= r_d_vld[j];
            end
            r_out_vld <= r_d_vld[rfcm_pkg::INDEX_BITS];
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_gray <= n_a_gray;
            r_a_num  <= n_num_full[rfcm_pkg::DATA_W-1:0];
            r_a_den  <= n_den_full[rfcm_pkg::DATA_W-1:0];

            r_d_gray[0] <= r_a_gray;
            r_d_den[0]  <= r_a_den;
            r_d_rem[0]  <= n_prod[rfcm_pkg::NUM_W-1 -: rfcm_pkg::DATA_W];
            r_d_lq[0]   <= n_prod[rfcm_pkg::INDEX_BITS-1:0];

            for (int j = 0; j < rfcm_pkg::INDEX_BITS; j++) begin
                r_d_gray[j+1] <= r_d_gray[j];
                r_d_den[j+1]  <= r_d_den[j];
                r_d_rem[j+1]  <= n_rem[j];
                r_d_lq[j+1]   <= n_lq[j];
            end

            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

`ifndef SYNTHESIS
    // No color is presented in the cycle after a reset.
    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("color valid right after reset");

    // Every color is mid gray or a rainbow color holding one full and one empty channel.
    a_color_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ((r_red == rfcm_pkg::CH_GRAY) && (r_green == rfcm_pkg::CH_GRAY)
                && (r_blue == rfcm_pkg::CH_GRAY))
            || (((r_red == rfcm_pkg::CH_MAX) || (r_green == rfcm_pkg::CH_MAX)
                    || (r_blue == rfcm_pkg::CH_MAX))
                && ((r_red == rfcm_pkg::CH_MIN) || (r_green == rfcm_pkg::CH_MIN)
                    || (r_blue == rfcm_pkg::CH_MIN))))
        else $error("color off the rainbow ramp");

    // An item in the clamp stage reaches the divider when the pipe advances.
    a_clamp_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_en && r_a_vld) |=> r_d_vld[0])
        else $error("item lost between clamp and divider");

    // The partial remainder stays below the divisor at every valid divider stage.
    for (genvar g = 0; g <= rfcm_pkg::INDEX_BITS; g++) begin : g_rem_chk
        a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (r_d_vld[g] && !r_d_gray[g]) |-> (r_d_rem[g] < r_d_den[g]))
            else $error("divider remainder out of bound");
    end
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rainbow_false_color_mapper: directed vectors, then random pixels.
// Depends on rfcm_pkg and the block's RTL only; colors are checked against an in-bench predictor.

module tb_top;

    // One mapped color, laid out as it appears on m_axis_tdata (red lowest).
    typedef struct packed {
        logic [rfcm_pkg::CH_W-1:0] blue;
        logic [rfcm_pkg::CH_W-1:0] green;
        logic [rfcm_pkg::CH_W-1:0] red;
    } t_rgb;

    // One row of the directed table; the color is used only when it is typed in.
    typedef struct {
        logic [rfcm_pkg::DATA_W-1:0] low;
        logic [rfcm_pkg::DATA_W-1:0] high;
        logic [rfcm_pkg::DATA_W-1:0] sample;
        bit                          typed;
        t_rgb                        color;
    } t_vector;

    localparam t_rgb PURE_BLUE = '{blue: rfcm_pkg::CH_MAX, green: rfcm_pkg::CH_MIN,
                                   red: rfcm_pkg::CH_MIN};
    localparam t_rgb PURE_RED  = '{blue: rfcm_pkg::CH_MIN, green: rfcm_pkg::CH_MIN,
                                   red: rfcm_pkg::CH_MAX};
    localparam t_rgb MID_GRAY  = '{blue: rfcm_pkg::CH_GRAY, green: rfcm_pkg::CH_GRAY,
                                   red: rfcm_pkg::CH_GRAY};
    localparam t_rgb NO_COLOR  = '{blue: rfcm_pkg::CH_MIN, green: rfcm_pkg::CH_MIN,
                                   red: rfcm_pkg::CH_MIN};

    localparam longint INDEX_MAX = (longint'(1) << rfcm_pkg::INDEX_BITS) - 1;
    localparam longint SEG_LEN   = longint'(1) << rfcm_pkg::FRAC_BITS;

    localparam int STALL_LIMIT    = 5000;
    localparam int RX_HOLD_CYCLES = 300;

    logic                                i_clk;
    logic                                i_rst_n       = 1'b0;
    logic                                i_cfg_we      = 1'b0;
    logic [rfcm_pkg::CFG_IDX_W-1:0]      i_cfg_idx     = rfcm_pkg::REG_RANGE_LOW;
    logic [rfcm_pkg::DATA_W-1:0]         i_cfg_wdata   = '0;
    logic                                s_axis_tvalid = 1'b0;
    logic                                s_axis_tready;
    logic [rfcm_pkg::S_TDATA_W-1:0]      s_axis_tdata  = '0;  // [31:0] sample
    logic                                m_axis_tvalid;
    logic                                m_axis_tready = 1'b0;
    logic [rfcm_pkg::M_TDATA_W-1:0]      m_axis_tdata;        // [7:0] red, [15:8] green,
                                                              // [23:16] blue

    // Bench copy of the range registers, kept in step with every write.
    logic signed [rfcm_pkg::DATA_W-1:0] cur_low  = rfcm_pkg::RANGE_LOW_RST;
    logic signed [rfcm_pkg::DATA_W-1:0] cur_high = rfcm_pkg::RANGE_HIGH_RST;

    t_rgb pending_colors[$];
    int   mismatch_count = 0;
    int   send_idle_pct  = 36;
    int   recv_idle_pct  = 84;
    logic rx_hold        = 1'b0;
    event long_stall_ev;

    // Directed vectors: reset range, full signed range, empty and inverted ranges,
    // a one-step range and a range that straddles zero.
    t_vector directed_vectors [0:22] = '{
        '{32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1, PURE_BLUE},
        '{32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, PURE_RED},
        '{32'h0000_0000, 32'h0001_0000, 32'h8000_0000, 1'b1, PURE_BLUE},
        '{32'h0000_0000, 32'h0001_0000, 32'h7FFF_FFFF, 1'b1, PURE_RED},
        '{32'h0000_0000, 32'h0001_0000, 32'h0000_3FFF, 1'b0, NO_COLOR},
        '{32'h0000_0000, 32'h0001_0000, 32'h0000_4000, 1'b0, NO_COLOR},
        '{32'h0000_0000, 32'h0001_0000, 32'h0000_8000, 1'b0, NO_COLOR},
        '{32'h0000_0000, 32'h0001_0000, 32'h0000_C000, 1'b0, NO_COLOR},
        '{32'h0000_0000, 32'h0001_0000, 32'h0000_FFFF, 1'b0, NO_COLOR},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, PURE_BLUE},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, PURE_RED},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, NO_COLOR},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'hC000_0000, 1'b0, NO_COLOR},
        '{32'h8000_0000, 32'h7FFF_FFFF, 32'h3FFF_FFFF, 1'b0, NO_COLOR},
        '{32'h1234_5678, 32'h1234_5678, 32'h1234_5678, 1'b1, MID_GRAY},
        '{32'h1234_5678, 32'h1234_5678, 32'h0000_0000, 1'b1, MID_GRAY},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'h55AA_55AA, 1'b1, MID_GRAY},
        '{32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, MID_GRAY},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, PURE_BLUE},
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0000, 1'b1, PURE_RED},
        '{32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0, NO_COLOR},
        '{32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000, 1'b0, NO_COLOR},
        '{32'hFFFF_0000, 32'h0001_0000, 32'hFFFF_8000, 1'b0, NO_COLOR}
    };

    rainbow_false_color_mapper dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Expected color: clamp, scale exactly to the ramp index, then pick the segment.
    function automatic t_rgb rainbow_color(input logic signed [rfcm_pkg::DATA_W-1:0] smp,
                                           input logic signed [rfcm_pkg::DATA_W-1:0] lo,
                                           input logic signed [rfcm_pkg::DATA_W-1:0] hi);
        longint         v, l, h, k, pos, rise, fall;
        rfcm_pkg::t_seg seg;
        t_rgb           c;
        v = smp;
        l = lo;
        h = hi;
        if (h <= l) begin
            return MID_GRAY;
        end
        if (v < l) v = l;
        if (v > h) v = h;
        k = (v - l) * INDEX_MAX / (h - l);
        if (k > INDEX_MAX) k = INDEX_MAX;
        seg  = rfcm_pkg::t_seg'(2'((k >> rfcm_pkg::FRAC_BITS) & 3));
        pos  = k & (SEG_LEN - 1);
        rise = (pos * 255) >> rfcm_pkg::FRAC_BITS;
        fall = ((SEG_LEN - pos) * 255) >> rfcm_pkg::FRAC_BITS;
        if (rise > 255) rise = 255;
        if (fall > 255) fall = 255;
        case (seg)
            rfcm_pkg::SEG_BLUE_CYAN: begin
                c = '{blue: rfcm_pkg::CH_MAX, green: rfcm_pkg::CH_W'(rise),
                      red: rfcm_pkg::CH_MIN};
            end
            rfcm_pkg::SEG_CYAN_GREEN: begin
                c = '{blue: rfcm_pkg::CH_W'(fall), green: rfcm_pkg::CH_MAX,
                      red: rfcm_pkg::CH_MIN};
            end
            rfcm_pkg::SEG_GREEN_YELLOW: begin
                c = '{blue: rfcm_pkg::CH_MIN, green: rfcm_pkg::CH_MAX,
                      red: rfcm_pkg::CH_W'(rise)};
            end
            default: begin
                c = '{blue: rfcm_pkg::CH_MIN, green: rfcm_pkg::CH_W'(fall),
                      red: rfcm_pkg::CH_MAX};
            end
        endcase
        return c;
    endfunction

    // Random pixel: mostly inside the current range, some near its bounds, some anywhere.
    function automatic logic [rfcm_pkg::DATA_W-1:0] random_sample();
        longint      l, h, span;
        logic [63:0] r;
        int          pick;
        l    = cur_low;
        h    = cur_high;
        r    = {$urandom, $urandom};
        pick = $urandom_range(99);
        if (h <= l || pick < 15) begin
            return $urandom;
        end
        span = h - l;
        if (pick < 25) begin
            return rfcm_pkg::DATA_W'(l + $urandom_range(4) - 2);
        end
        if (pick < 35) begin
            return rfcm_pkg::DATA_W'(h + $urandom_range(4) - 2);
        end
        return rfcm_pkg::DATA_W'(l + longint'(r % 64'(span + 1)));
    endfunction

    // Offer one pixel, idling at random first, and record its color once the transaction completes.
    task automatic send_sample(input logic [rfcm_pkg::DATA_W-1:0] smp, input t_rgb want);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_colors.push_back(want);
    endtask

    // Stop offering pixels and wait until every color in flight has come out.
    task automatic drain();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_colors.size() != 0) @(posedge i_clk);
    endtask

    // Write both range registers; the pipeline must be empty.
    task automatic write_range(input logic [rfcm_pkg::DATA_W-1:0] lo,
                               input logic [rfcm_pkg::DATA_W-1:0] hi);
        drain();
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= rfcm_pkg::REG_RANGE_LOW;
        i_cfg_wdata <= lo;
        @(negedge i_clk);
        i_cfg_idx   <= rfcm_pkg::REG_RANGE_HIGH;
        i_cfg_wdata <= hi;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_low  = lo;
        cur_high = hi;
    endtask

    // Color stream ready, with random idling and the long hold-off.
    always @(negedge i_clk) begin
        m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_idle_pct);
    end

    // Long hold-off on the color stream, so the pipeline fills and stalls its input.
    initial begin
        @(long_stall_ev);
        @(negedge i_clk);
        rx_hold <= 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge i_clk);
        rx_hold <= 1'b0;
    end

    // Compare each color transaction with the oldest expected color.
    always @(posedge i_clk) begin
        t_rgb got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_rgb'(m_axis_tdata);
            if (pending_colors.size() == 0) begin
                $error("unexpected color transaction: tdata %06h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_colors.pop_front();
                if (got.red !== want.red) begin
                    $error("red: expected %02h, got %02h", want.red, got.red);
                    mismatch_count++;
                end
                if (got.green !== want.green) begin
                    $error("green: expected %02h, got %02h", want.green, got.green);
                    mismatch_count++;
                end
                if (got.blue !== want.blue) begin
                    $error("blue: expected %02h, got %02h", want.blue, got.blue);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: ends the run when no transaction happens for too long.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("** rainbow_false_color_mapper: FAILED **");
        $finish;
    end

    // Main sequence: reset, directed table, then random phases.
    initial begin : stimulus
        t_rgb        want;
        logic [31:0] smp, a, b;
        int          count;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part; the first rows run on the reset range.
        foreach (directed_vectors[i]) begin
            if (directed_vectors[i].low != cur_low || directed_vectors[i].high != cur_high) begin
                write_range(directed_vectors[i].low, directed_vectors[i].high);
            end
            smp  = directed_vectors[i].sample;
            want = directed_vectors[i].typed ? directed_vectors[i].color
                                             : rainbow_color(smp, cur_low, cur_high);
            send_sample(smp, want);
        end

        // Random phases, each with its own range; the first three also set their own idling pattern.
        for (int phase = 0; phase < 5; phase++) begin
            a = $urandom;
            b = $urandom;
            case (phase)
                0: begin
                    send_idle_pct = 36;
                    recv_idle_pct = 84;
                    count = 150;
                    write_range(32'hFFF0_0000, 32'h0010_0000);
                end
                1: begin
                    send_idle_pct = 84;
                    recv_idle_pct = 36;
                    count = 150;
                    write_range(32'h8000_0000, 32'h7FFF_FFFF);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    count = 150;
                    if ($signed(a) <= $signed(b)) write_range(a, b);
                    else write_range(b, a);
                end
                3: begin
                    // Very narrow range: at most 201 index values are reachable.
                    count = 50;
                    write_range(a, a + $urandom_range(200, 1));
                end
                default: begin
                    // Empty or inverted range, unless the subtraction wraps: every pixel comes out gray.
                    count = 25;
                    write_range(a, a - $urandom_range(1000));
                end
            endcase
            for (int n = 0; n < count; n++) begin
                if (phase == 2 && n == 20) begin
                    ->long_stall_ev;
                end
                if (phase == 2 && n == 100) begin
                    drain();
                end
                smp = random_sample();
                send_sample(smp, rainbow_color(smp, cur_low, cur_high));
            end
        end

        drain();
        repeat (rfcm_pkg::PIPE_STAGES + 10) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("** rainbow_false_color_mapper: PASSED **");
        end else begin
            $display("** rainbow_false_color_mapper: FAILED **");
        end
        $finish;
    end

endmodule
